// File: src/ryb_pkg.sv
// ryb_pkg: widths, color conversion coefficients, weight table and register codes
// for the rgba over yuv blend block; no dependencies
`default_nettype none

package ryb_pkg;

  // field widths
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned REG_W    = COORD_W + 1;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned TRANSP_W = 7;
  localparam int unsigned CFG_IDX_W = 2;

  // q16 weight runs 0..65536, needs 17 bits
  localparam int unsigned WT_W     = 17;
  // one coefficient product, 8 bit sample times 16 bit coefficient
  localparam int unsigned PROD_W   = 24;
  // converted sample minus base, signed, magnitude below 2^24
  localparam int unsigned DIFF_W   = 26;
  // full diff times weight product
  localparam int unsigned MUL_W    = DIFF_W + WT_W + 1;
  // top bits of the product kept for the final add, signed
  localparam int unsigned HI_W     = MUL_W - 32;
  // window compare width, signed
  localparam int unsigned WIN_W    = REG_W + 2;

  // q16 color conversion coefficients (magnitudes, signs applied in the sums)
  localparam logic [15:0] CY_R = 16'd19595;
  localparam logic [15:0] CY_G = 16'd38470;
  localparam logic [15:0] CY_B = 16'd7471;
  localparam logic [15:0] CU_R = 16'd11076;
  localparam logic [15:0] CU_G = 16'd21758;
  localparam logic [15:0] CU_B = 16'd32768;
  localparam logic [15:0] CV_R = 16'd32768;
  localparam logic [15:0] CV_G = 16'd27460;
  localparam logic [15:0] CV_B = 16'd5308;
  localparam logic [DIFF_W-1:0] CHROMA_OFS = DIFF_W'(128 * 65536);

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  // configuration register codes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Y = 2'd1,
    REG_WIDTH    = 2'd2,
    REG_HEIGHT   = 2'd3
  } cfg_reg_e;

  // overlay weight per transparency: ((127 - t) * 65536 + 63) / 127
  typedef logic [WT_W-1:0] weight_lut_t [2**TRANSP_W];

  function automatic weight_lut_t build_weight_lut();
    weight_lut_t lut;
    for (int i = 0; i < 2**TRANSP_W; i++) begin
      lut[i] = WT_W'(((127 - i) * 65536 + 63) / 127);
    end
    return lut;
  endfunction

  localparam weight_lut_t WEIGHT_LUT = build_weight_lut();

endpackage

`default_nettype wire

// File: src/ryb_mix.sv
// ryb_mix: one channel of the blend, weight multiply then add to base and clamp
// depends on ryb_pkg
`default_nettype none

module ryb_mix (
  input  wire logic                          clk_i,
  input  wire logic [ryb_pkg::DIFF_W-1:0]    diff_i,
  input  wire logic [ryb_pkg::WT_W-1:0]      weight_i,
  input  wire logic [ryb_pkg::SAMPLE_W-1:0]  base_i,
  output logic      [ryb_pkg::SAMPLE_W-1:0]  result_o
);
  import ryb_pkg::*;

  logic signed [MUL_W-1:0]    prod_d;
  logic signed [HI_W-1:0]     hi_q;
  logic        [SAMPLE_W-1:0] base_q;
  logic signed [HI_W-1:0]     sum_d;
  logic        [SAMPLE_W-1:0] result_d;
  logic        [SAMPLE_W-1:0] result_q;

  // signed diff times unsigned weight; only the part above 2^32 matters
  assign prod_d = $signed(diff_i) * $signed({1'b0, weight_i});

  always_ff @(posedge clk_i) begin
    hi_q   <= prod_d[MUL_W-1:32];
    base_q <= base_i;
  end

  // base plus floored scaled difference, clamped to the sample range
  assign sum_d = $signed({{(HI_W - SAMPLE_W){1'b0}}, base_q}) + hi_q;

  always_comb begin
    priority if (sum_d < 0) begin
      result_d = '0;
    end else if (sum_d > $signed(HI_W'(SAMPLE_MAX))) begin
      result_d = SAMPLE_MAX;
    end else begin
      result_d = sum_d[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

// File: src/rgba_over_yuv_blend.sv
// rgba_over_yuv_blend: top level, window test, rgb to yuv conversion and blend pipeline
// depends on ryb_pkg and ryb_mix
`default_nettype none

// Composites one RGBA overlay pixel onto one 4:4:4 YUV frame pixel for each item.
// An item is taken on every cycle that start_i is high; busy_o never rises, and
// each item gives exactly one result, shown for one cycle with out_valid_o once it
// has passed the four register stages: window test with weight lookup and
// coefficient products, conversion sums, weight multiply, then add and clamp.
// Results keep input order and cannot be held off by the receiver. Inside the
// window set by the origin and size registers the base sample is blended with
// the converted overlay color at weight (127 - transparency) / 127; outside it
// the base passes unchanged and inside_window_o is low. Write configuration
// only while no item is in flight.
module rgba_over_yuv_blend (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // item handshake
  input  wire logic                           start_i,
  output logic                                busy_o,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [ryb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ryb_pkg::REG_W-1:0]      cfg_data_i,
  // input item
  input  wire logic [ryb_pkg::COORD_W-1:0]    pixel_col_i,
  input  wire logic [ryb_pkg::COORD_W-1:0]    pixel_row_i,
  input  wire logic [ryb_pkg::SAMPLE_W-1:0]   base_luma_i,
  input  wire logic [ryb_pkg::SAMPLE_W-1:0]   base_cb_i,
  input  wire logic [ryb_pkg::SAMPLE_W-1:0]   base_cr_i,
  input  wire logic [ryb_pkg::SAMPLE_W-1:0]   over_red_i,
  input  wire logic [ryb_pkg::SAMPLE_W-1:0]   over_green_i,
  input  wire logic [ryb_pkg::SAMPLE_W-1:0]   over_blue_i,
  input  wire logic [ryb_pkg::TRANSP_W-1:0]   over_transparency_i,
  // result item
  output logic                                out_valid_o,
  output logic      [ryb_pkg::SAMPLE_W-1:0]   out_luma_o,
  output logic      [ryb_pkg::SAMPLE_W-1:0]   out_cb_o,
  output logic      [ryb_pkg::SAMPLE_W-1:0]   out_cr_o,
  output logic                                inside_window_o
);
  import ryb_pkg::*;

  // configuration registers
  logic [REG_W-1:0] origin_x_q;
  logic [REG_W-1:0] origin_y_q;
  logic [REG_W-1:0] ovl_w_q;
  logic [REG_W-1:0] ovl_h_q;

  // stage a: window, weight, coefficient products
  logic                    accept;
  logic signed [WIN_W-1:0] col_s, row_s, ox_s, oy_s, end_x_s, end_y_s;
  logic                    win_d;
  logic                    vld_a_q, inside_a_q;
  logic [WT_W-1:0]         wt_a_d, wt_a_q;
  logic [SAMPLE_W-1:0]     by_a_q, bu_a_q, bv_a_q;
  logic [PROD_W-1:0]       yr_q, yg_q, yb_q, ur_q, ug_q, ub_q, vr_q, vg_q, vb_q;

  // stage b: converted samples minus base
  logic [DIFF_W-1:0]       conv_y_d, conv_u_d, conv_v_d;
  logic [DIFF_W-1:0]       diff_y_q, diff_u_q, diff_v_q;
  logic                    vld_b_q, inside_b_q;
  logic [WT_W-1:0]         wt_b_q;
  logic [SAMPLE_W-1:0]     by_b_q, bu_b_q, bv_b_q;

  // stages c and d: valid and window flag follow the channel units
  logic                    vld_c_q, inside_c_q;
  logic                    out_valid_q, inside_q;

  // every cycle can take an item
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      ovl_w_q    <= '0;
      ovl_h_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X: origin_x_q <= cfg_data_i;
        REG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        REG_WIDTH:    ovl_w_q    <= cfg_data_i;
        REG_HEIGHT:   ovl_h_q    <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // window test at full width, right and bottom edges exclusive
  assign col_s   = $signed({{(WIN_W - COORD_W){1'b0}}, pixel_col_i});
  assign row_s   = $signed({{(WIN_W - COORD_W){1'b0}}, pixel_row_i});
  assign ox_s    = $signed({{(WIN_W - REG_W){origin_x_q[REG_W-1]}}, origin_x_q});
  assign oy_s    = $signed({{(WIN_W - REG_W){origin_y_q[REG_W-1]}}, origin_y_q});
  assign end_x_s = ox_s + $signed({{(WIN_W - REG_W){1'b0}}, ovl_w_q});
  assign end_y_s = oy_s + $signed({{(WIN_W - REG_W){1'b0}}, ovl_h_q});
  assign win_d   = (col_s >= ox_s) && (row_s >= oy_s) &&
                   (col_s < end_x_s) && (row_s < end_y_s);

  // outside the window a zero weight passes the base through unchanged
  assign wt_a_d = win_d ? WEIGHT_LUT[over_transparency_i] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q    <= 1'b0;
      inside_a_q <= 1'b0;
    end else begin
      vld_a_q    <= accept;
      inside_a_q <= accept && win_d;
    end
  end

  // constant coefficient products, with the weight and base samples registered alongside
  always_ff @(posedge clk_i) begin
    wt_a_q <= wt_a_d;
    by_a_q <= base_luma_i;
    bu_a_q <= base_cb_i;
    bv_a_q <= base_cr_i;
    yr_q   <= PROD_W'(over_red_i)   * PROD_W'(CY_R);
    yg_q   <= PROD_W'(over_green_i) * PROD_W'(CY_G);
    yb_q   <= PROD_W'(over_blue_i)  * PROD_W'(CY_B);
    ur_q   <= PROD_W'(over_red_i)   * PROD_W'(CU_R);
    ug_q   <= PROD_W'(over_green_i) * PROD_W'(CU_G);
    ub_q   <= PROD_W'(over_blue_i)  * PROD_W'(CU_B);
    vr_q   <= PROD_W'(over_red_i)   * PROD_W'(CV_R);
    vg_q   <= PROD_W'(over_green_i) * PROD_W'(CV_G);
    vb_q   <= PROD_W'(over_blue_i)  * PROD_W'(CV_B);
  end

  // conversion sums, all converted samples are non-negative and below 2^24
  assign conv_y_d = DIFF_W'(yr_q) + DIFF_W'(yg_q) + DIFF_W'(yb_q);
  assign conv_u_d = CHROMA_OFS + DIFF_W'(ub_q) - DIFF_W'(ur_q) - DIFF_W'(ug_q);
  assign conv_v_d = CHROMA_OFS + DIFF_W'(vr_q) - DIFF_W'(vg_q) - DIFF_W'(vb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q    <= 1'b0;
      inside_b_q <= 1'b0;
    end else begin
      vld_b_q    <= vld_a_q;
      inside_b_q <= inside_a_q;
    end
  end

  // difference to the base in q16, wraps to a signed value
  always_ff @(posedge clk_i) begin
    diff_y_q <= conv_y_d - {2'b00, by_a_q, 16'h0000};
    diff_u_q <= conv_u_d - {2'b00, bu_a_q, 16'h0000};
    diff_v_q <= conv_v_d - {2'b00, bv_a_q, 16'h0000};
    wt_b_q   <= wt_a_q;
    by_b_q   <= by_a_q;
    bu_b_q   <= bu_a_q;
    bv_b_q   <= bv_a_q;
  end

  // per channel multiply, add and clamp
  ryb_mix u_mix_y (
    .clk_i    (clk_i),
    .diff_i   (diff_y_q),
    .weight_i (wt_b_q),
    .base_i   (by_b_q),
    .result_o (out_luma_o)
  );

  ryb_mix u_mix_u (
    .clk_i    (clk_i),
    .diff_i   (diff_u_q),
    .weight_i (wt_b_q),
    .base_i   (bu_b_q),
    .result_o (out_cb_o)
  );

  ryb_mix u_mix_v (
    .clk_i    (clk_i),
    .diff_i   (diff_v_q),
    .weight_i (wt_b_q),
    .base_i   (bv_b_q),
    .result_o (out_cr_o)
  );

  // valid and window flag aligned with the channel results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q     <= 1'b0;
      inside_c_q  <= 1'b0;
      out_valid_q <= 1'b0;
      inside_q    <= 1'b0;
    end else begin
      vld_c_q     <= vld_b_q;
      inside_c_q  <= inside_b_q;
      out_valid_q <= vld_c_q;
      inside_q    <= inside_c_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign inside_window_o = inside_q;

  // results come only from items that went through every stage
  a_valid_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(vld_c_q) && $past(vld_b_q, 2) && $past(vld_a_q, 3))
    else $error("result without an item in every stage");

  // window flag never shows without a result
  a_inside_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inside_window_o |-> out_valid_o)
    else $error("window flag without a result");

  // an empty window marks no item inside
  a_empty_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && (ovl_w_q == '0 || ovl_h_q == '0)) |=> !inside_a_q)
    else $error("item marked inside an empty window");

  // outside the window the base samples pass unchanged
  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !inside_window_o) |->
      (out_luma_o == $past(base_luma_i, 4) && out_cb_o == $past(base_cb_i, 4) &&
       out_cr_o == $past(base_cr_i, 4)))
    else $error("base samples changed outside the window");

endmodule

`default_nettype wire

// File: sim/rgba_over_yuv_blend_tb.sv
// rgba_over_yuv_blend_tb: self-checking bench for the rgba over yuv blend block
// predicts each blended pixel from its own window and color math and compares results
// depends on ryb_pkg and rgba_over_yuv_blend
`timescale 1ns / 100ps

module rgba_over_yuv_blend_tb;
  import ryb_pkg::*;

  localparam int unsigned STALL_LIMIT = 300;
  // pipeline is four deep, give it a little extra before a register write
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned RAND_PHASES = 10;
  localparam int unsigned PIXELS_PER_PHASE = 75;

  typedef enum logic {
    OP_PIXEL,
    OP_REG_WRITE
  } op_kind_e;

  typedef struct {
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [SAMPLE_W-1:0] luma;
    logic [SAMPLE_W-1:0] cb;
    logic [SAMPLE_W-1:0] cr;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic [TRANSP_W-1:0] transp;
  } pixel_t;

  typedef struct {
    logic [SAMPLE_W-1:0] luma;
    logic [SAMPLE_W-1:0] cb;
    logic [SAMPLE_W-1:0] cr;
    logic                in_win;
  } blended_t;

  typedef struct {
    op_kind_e          kind;
    pixel_t            px;
    cfg_reg_e          reg_idx;
    logic [REG_W-1:0]  reg_val;
    int unsigned       gap;
  } stim_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  cfg_reg_e cfg_idx = REG_ORIGIN_X;
  logic [REG_W-1:0] cfg_data = '0;
  logic [COORD_W-1:0] pixel_col = '0;
  logic [COORD_W-1:0] pixel_row = '0;
  logic [SAMPLE_W-1:0] base_luma = '0;
  logic [SAMPLE_W-1:0] base_cb = '0;
  logic [SAMPLE_W-1:0] base_cr = '0;
  logic [SAMPLE_W-1:0] over_red = '0;
  logic [SAMPLE_W-1:0] over_green = '0;
  logic [SAMPLE_W-1:0] over_blue = '0;
  logic [TRANSP_W-1:0] over_transparency = '0;
  logic out_valid;
  logic [SAMPLE_W-1:0] out_luma;
  logic [SAMPLE_W-1:0] out_cb;
  logic [SAMPLE_W-1:0] out_cr;
  logic inside_window;

  // shadow of the window registers
  logic signed [REG_W-1:0] win_x = '0;
  logic signed [REG_W-1:0] win_y = '0;
  logic [REG_W-1:0] win_w = '0;
  logic [REG_W-1:0] win_h = '0;

  stim_op_t pending_ops[$];
  blended_t blended_q[$];
  bit item_live = 1'b0;
  bit no_idle = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_cycles = 0;
  int unsigned err_cnt = 0;

  rgba_over_yuv_blend u_top (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .start_i             (start),
    .busy_o              (busy),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_data_i          (cfg_data),
    .pixel_col_i         (pixel_col),
    .pixel_row_i         (pixel_row),
    .base_luma_i         (base_luma),
    .base_cb_i           (base_cb),
    .base_cr_i           (base_cr),
    .over_red_i          (over_red),
    .over_green_i        (over_green),
    .over_blue_i         (over_blue),
    .over_transparency_i (over_transparency),
    .out_valid_o         (out_valid),
    .out_luma_o          (out_luma),
    .out_cb_o            (out_cb),
    .out_cr_o            (out_cr),
    .inside_window_o     (inside_window)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // one channel: base weighted by 1 - w plus converted sample weighted by w, q16
  function automatic logic [SAMPLE_W-1:0] mix_channel(logic [SAMPLE_W-1:0] base,
                                                      longint conv, longint wt);
    longint b;
    longint acc;
    b = base;
    acc = b * 65536 * (65536 - wt) + conv * wt;
    if (acc < 0) acc = 0;
    acc = acc >>> 32;
    if (acc > 255) acc = 255;
    return SAMPLE_W'(acc);
  endfunction

  function automatic blended_t predict_blend(pixel_t p);
    longint col, row, x0, y0, ww, hh;
    longint r, g, b, wt, cy, cu, cv;
    blended_t res;
    col = p.col;
    row = p.row;
    x0 = win_x;
    y0 = win_y;
    ww = win_w;
    hh = win_h;
    res.in_win = (col >= x0) && (row >= y0) && (col < x0 + ww) && (row < y0 + hh);
    if (res.in_win) begin
      r = p.red;
      g = p.green;
      b = p.blue;
      wt = ((127 - longint'(p.transp)) * 65536 + 63) / 127;
      cy = 19595 * r + 38470 * g + 7471 * b;
      cu = -11076 * r - 21758 * g + 32768 * b + 128 * 65536;
      cv = 32768 * r - 27460 * g - 5308 * b + 128 * 65536;
      res.luma = mix_channel(p.luma, cy, wt);
      res.cb = mix_channel(p.cb, cu, wt);
      res.cr = mix_channel(p.cr, cv, wt);
    end else begin
      res.luma = p.luma;
      res.cb = p.cb;
      res.cr = p.cr;
    end
    return res;
  endfunction

  function automatic int unsigned draw_gap();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  // coordinate around the window edges, clipped to the frame
  function automatic int pick_coord(int org, int len);
    int lo, hi;
    lo = org - 2;
    hi = org + len + 1;
    if (lo < 0) lo = 0;
    if (hi > 4095) hi = 4095;
    if (lo > hi) return $urandom_range(0, 4095);
    return $urandom_range(hi, lo);
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic int rand_origin();
    case ($urandom_range(0, 7))
      0: return -4096;
      1: return 4095;
      2: return int'($urandom_range(0, 8191)) - 4096;
      default: return int'($urandom_range(0, 4000)) - 32;
    endcase
  endfunction

  function automatic int rand_size();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 4096;
      2: return $urandom_range(0, 4096);
      default: return $urandom_range(1, 48);
    endcase
  endfunction

  task automatic add_reg(cfg_reg_e idx, int val);
    stim_op_t op;
    op.kind = OP_REG_WRITE;
    op.reg_idx = idx;
    op.reg_val = REG_W'(val);
    op.gap = 0;
    pending_ops.push_back(op);
  endtask

  task automatic add_window(int x, int y, int w, int h);
    add_reg(REG_ORIGIN_X, x);
    add_reg(REG_ORIGIN_Y, y);
    add_reg(REG_WIDTH, w);
    add_reg(REG_HEIGHT, h);
  endtask

  task automatic add_pixel(pixel_t p);
    stim_op_t op;
    op.kind = OP_PIXEL;
    op.px = p;
    op.gap = draw_gap();
    pending_ops.push_back(op);
  endtask

  task automatic add_fixed(int col, int row, int y, int u, int v,
                           int r, int g, int b, int t);
    pixel_t p;
    p.col = COORD_W'(col);
    p.row = COORD_W'(row);
    p.luma = SAMPLE_W'(y);
    p.cb = SAMPLE_W'(u);
    p.cr = SAMPLE_W'(v);
    p.red = SAMPLE_W'(r);
    p.green = SAMPLE_W'(g);
    p.blue = SAMPLE_W'(b);
    p.transp = TRANSP_W'(t);
    add_pixel(p);
  endtask

  task automatic note_error(string what);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("%0t: mismatch: %s", $time, what);
  endtask

  task automatic check_sample(string name, logic [SAMPLE_W-1:0] want,
                              logic [SAMPLE_W-1:0] got);
    if (got !== want) note_error($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  // driver: pixels go out after their gap, register writes only once the pipe is empty
  always @(posedge clk) begin : pixel_driver
    stim_op_t op;
    logic start_n;
    logic we_n;
    start_n = start;
    we_n = 1'b0;
    if (rst_n) begin
      if (start && !busy) item_live = 1'b0;
      if (item_live || blended_q.size() != 0) quiet_cycles = 0;
      else if (quiet_cycles < SETTLE_CYCLES) quiet_cycles++;
      if (!item_live) begin
        start_n = 1'b0;
        if (pending_ops.size() != 0) begin
          if (pending_ops[0].kind == OP_PIXEL) begin
            if (pending_ops[0].gap != 0) begin
              pending_ops[0].gap--;
            end else begin
              op = pending_ops.pop_front();
              pixel_col <= op.px.col;
              pixel_row <= op.px.row;
              base_luma <= op.px.luma;
              base_cb <= op.px.cb;
              base_cr <= op.px.cr;
              over_red <= op.px.red;
              over_green <= op.px.green;
              over_blue <= op.px.blue;
              over_transparency <= op.px.transp;
              // expectation queued as the item goes out, ahead of its result
              blended_q.push_back(predict_blend(op.px));
              start_n = 1'b1;
              item_live = 1'b1;
            end
          end else if (quiet_cycles >= SETTLE_CYCLES) begin
            op = pending_ops.pop_front();
            we_n = 1'b1;
            cfg_idx <= op.reg_idx;
            cfg_data <= op.reg_val;
            case (op.reg_idx)
              REG_ORIGIN_X: win_x = op.reg_val;
              REG_ORIGIN_Y: win_y = op.reg_val;
              REG_WIDTH:    win_w = op.reg_val;
              REG_HEIGHT:   win_h = op.reg_val;
              default: ;
            endcase
          end
        end
      end
      start <= start_n;
      cfg_we <= we_n;
    end
  end

  // monitor: every strobed result against the oldest expectation
  always @(posedge clk) begin : result_monitor
    blended_t want;
    if (rst_n && out_valid) begin
      if (blended_q.size() == 0) begin
        note_error($sformatf("unexpected result luma %0d cb %0d cr %0d inside %0b",
                             out_luma, out_cb, out_cr, inside_window));
      end else begin
        want = blended_q.pop_front();
        check_sample("luma", want.luma, out_luma);
        check_sample("cb", want.cb, out_cb);
        check_sample("cr", want.cr, out_cr);
        check_sample("inside_window", SAMPLE_W'(want.in_win), SAMPLE_W'(inside_window));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin : stall_watchdog
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("rgba_over_yuv_blend_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    pixel_t p;
    int wx, wy, ww, wh;
    bit near;

    // reset window is empty
    add_fixed(0, 0, 255, 0, 128, 255, 255, 255, 0);
    add_fixed(4095, 4095, 17, 200, 3, 0, 0, 0, 0);

    // whole frame inside: color extremes and transparency ends
    add_window(0, 0, 4096, 4096);
    add_fixed(0, 0, 0, 0, 0, 255, 255, 255, 0);
    add_fixed(4095, 4095, 255, 255, 255, 0, 0, 0, 0);
    add_fixed(100, 200, 40, 90, 160, 0, 0, 255, 0);
    add_fixed(101, 200, 40, 90, 160, 255, 0, 0, 0);
    add_fixed(102, 200, 255, 255, 255, 255, 255, 0, 0);
    add_fixed(103, 200, 0, 0, 0, 0, 255, 0, 0);
    add_fixed(2730, 1365, 170, 85, 51, 77, 199, 12, 127);
    add_fixed(1365, 2730, 255, 0, 255, 255, 0, 255, 1);
    add_fixed(7, 9, 128, 128, 128, 200, 100, 50, 126);
    add_fixed(8, 9, 0, 255, 0, 255, 255, 255, 64);

    // window edges, left and top inclusive, right and bottom exclusive
    add_window(10, 20, 5, 3);
    add_fixed(9, 20, 60, 70, 80, 255, 0, 0, 0);
    add_fixed(10, 20, 60, 70, 80, 255, 0, 0, 0);
    add_fixed(14, 22, 60, 70, 80, 0, 255, 0, 0);
    add_fixed(15, 20, 60, 70, 80, 0, 255, 0, 0);
    add_fixed(10, 19, 60, 70, 80, 0, 0, 255, 0);
    add_fixed(10, 23, 60, 70, 80, 0, 0, 255, 0);

    // negative origins: window wholly left of the frame, then straddling it
    add_window(-4096, -4096, 4096, 4096);
    add_fixed(0, 0, 11, 22, 33, 255, 255, 255, 0);
    add_window(-1, -1, 2, 2);
    add_fixed(0, 0, 11, 22, 33, 255, 255, 255, 0);
    add_fixed(1, 0, 11, 22, 33, 255, 255, 255, 0);

    // largest origin, only the last frame pixel can be inside
    add_window(4095, 4095, 4096, 4096);
    add_fixed(4095, 4095, 90, 180, 45, 10, 20, 30, 5);
    add_fixed(4094, 4095, 90, 180, 45, 10, 20, 30, 5);

    // random phases, most pixels aimed around the window edges
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wx = rand_origin();
      wy = rand_origin();
      ww = rand_size();
      wh = rand_size();
      add_window(wx, wy, ww, wh);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PIXELS_PER_PHASE; k++) begin
        near = ($urandom_range(0, 9) < 8);
        p.col = near ? COORD_W'(pick_coord(wx, ww)) : COORD_W'($urandom_range(0, 4095));
        p.row = near ? COORD_W'(pick_coord(wy, wh)) : COORD_W'($urandom_range(0, 4095));
        p.luma = SAMPLE_W'(pick_sample());
        p.cb = SAMPLE_W'(pick_sample());
        p.cr = SAMPLE_W'(pick_sample());
        p.red = SAMPLE_W'(pick_sample());
        p.green = SAMPLE_W'(pick_sample());
        p.blue = SAMPLE_W'(pick_sample());
        case ($urandom_range(0, 7))
          0: p.transp = '0;
          1: p.transp = TRANSP_W'(127);
          default: p.transp = TRANSP_W'($urandom_range(0, 127));
        endcase
        add_pixel(p);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // drain, then leave room for any stray result
    while (pending_ops.size() != 0 || item_live || blended_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("rgba_over_yuv_blend_tb: done, clean");
    end else begin
      $display("rgba_over_yuv_blend_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
src/ryb_pkg.sv
src/ryb_mix.sv
src/rgba_over_yuv_blend.sv
sim/rgba_over_yuv_blend_tb.sv
